[rtl/frame_time_window_stats_macros.svh]
// ----------------------------------------------------------------------------
// Frame time window stats: assertion macros
// Concurrent check shorthands used by the asserting design file.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_WINDOW_STATS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATS_MACROS_SVH

// same-cycle implication
`define FTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fts check failed");

// next-cycle implication
`define FTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fts check failed");

`endif

[rtl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// Frame time window stats package
// Fixed widths, reset values, register indexes and command codes.
// ----------------------------------------------------------------------------
package fts_pkg;

   localparam int unsigned DATA_W  = 24;
   localparam int unsigned MINS_W  = 10;
   localparam int unsigned CSR_W   = 2;
   localparam int unsigned SCALE_W = 28;

   localparam logic [DATA_W-1:0]  MAX24       = 24'hFFFFFF;
   localparam logic [SCALE_W-1:0] RATE_SCALE  = 28'd256000000;

   localparam logic [DATA_W-1:0]  WARMUP_RST  = 24'd3000000;
   localparam logic [MINS_W-1:0]  MINS_RST    = 10'd100;
   localparam logic [DATA_W-1:0]  REFRESH_RST = 24'd250000;

   localparam logic [CSR_W-1:0] CSR_WARMUP  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MINS    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_REFRESH = 2'd2;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

[rtl/frame_time_window_stats.sv]
// ----------------------------------------------------------------------------
// Frame time window stats
// Sliding-window frame rate statistics: mean, 1% low and 0.1% low rates.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_command, req_frame_us
//  rsp     | out | rsp_valid/rsp_ready  | stats_ready, three rates, refreshed
//  csr     | in  | csr_wr_en            | csr_index, csr_wdata
//
//  A beat that does not recompute goes from STEP through PUB to the result.
//  A recompute scans the n window entries, drains the top list head by head,
//  then runs the shared bit-serial divider three times.
//  Synchronous reset clears control and statistics; the window RAM is kept.
//  A stalled rsp holds the next result in PUB; req is not taken while it waits.
// ----------------------------------------------------------------------------
`include "frame_time_window_stats_macros.svh"

module frame_time_window_stats #(
   parameter int unsigned WINDOW_DEPTH = 1000
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [fts_pkg::DATA_W-1:0]  req_frame_us,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_stats_ready,
   output logic [fts_pkg::DATA_W-1:0]  rsp_mean_rate,
   output logic [fts_pkg::DATA_W-1:0]  rsp_low_one_pct_rate,
   output logic [fts_pkg::DATA_W-1:0]  rsp_low_tenth_pct_rate,
   output logic                        rsp_refreshed,
   input  logic                        csr_wr_en,
   input  logic [fts_pkg::CSR_W-1:0]   csr_index,
   input  logic [fts_pkg::DATA_W-1:0]  csr_wdata
);

   localparam int unsigned DW    = fts_pkg::DATA_W;
   localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
   localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SW    = DW + CW;            // window sum
   localparam int unsigned PW    = CW + fts_pkg::SCALE_W;
   localparam int unsigned NUM_W = CW + fts_pkg::SCALE_W + 1;
   localparam int unsigned BW    = $clog2(NUM_W + 1);
   localparam int unsigned TOPK  = WINDOW_DEPTH / 100;  // largest k1 possible
   localparam int unsigned MW    = CW + fts_pkg::MINS_W;

   typedef enum logic [2:0] {
      IDLE, STEP, SCAN, TAIL, MUL, DLOAD, DRUN, PUB
   } state_type;

   // config
   logic [DW-1:0]                 warmup_ff, refresh_us_ff;
   logic [fts_pkg::MINS_W-1:0]    mins_ff;

   // statistics state
   logic [AW-1:0]  wp_ff;
   logic [CW-1:0]  fill_ff;
   logic [DW-1:0]  warm_ff, rtot_ff;
   logic           cready_ff;
   logic [DW-1:0]  mean_ff, low1_ff, low01_ff;

   // item and sequencing
   state_type      state_ff;
   logic           cmd_ff;
   logic [DW-1:0]  frame_ff;
   logic           refr_ff;

   // window RAM
   logic [DW-1:0]  mem [WINDOW_DEPTH];
   logic           mem_we;
   logic [AW-1:0]  rd_addr;
   logic [DW-1:0]  rd_data_ff;

   // scan
   logic [CW-1:0]  n_ff, issue_ff;
   logic           rd_vld_ff;
   logic [SW-1:0]  total_ff, tail1_ff, tail2_ff;
   logic [6:0]     c100_ff;
   logic [9:0]     c1000_ff;
   logic [CW-1:0]  k1_ff, k2_ff, tj_ff;
   logic [DW-1:0]  top_ff [TOPK];
   logic [DW-1:0]  top_in [TOPK];

   // divider
   logic [1:0]     sel_ff;
   logic [PW-1:0]  prod_ff;
   logic [SW-1:0]  div_ff;
   logic [NUM_W-1:0] num_ff;
   logic [SW:0]    rem_ff;
   logic [BW-1:0]  bit_ff;
   logic [CW-1:0]  k_sel;
   logic [SW-1:0]  s_sel;
   logic [SW:0]    rem_sh;
   logic           rem_ge;
   logic [DW-1:0]  q_sat;

   // output register
   logic           rsp_valid_ff, rsp_ready_flag_ff, rsp_refr_ff;
   logic [DW-1:0]  rsp_mean_ff, rsp_low1_ff, rsp_low01_ff;

   // step arithmetic
   logic [DW:0]    warm_add_in, rtot_add_in;
   logic [DW-1:0]  warm_in, rtot_in;
   logic           enter_in, recomp_in;
   logic [AW-1:0]  wp_in;
   logic [CW-1:0]  fill_in;
   logic           few_in;

   always_comb begin
      warm_add_in = {1'b0, warm_ff} + {1'b0, frame_ff};
      warm_in     = warm_add_in[DW] ? fts_pkg::MAX24 : warm_add_in[DW-1:0];
      rtot_add_in = {1'b0, rtot_ff} + {1'b0, frame_ff};
      rtot_in     = rtot_add_in[DW] ? fts_pkg::MAX24 : rtot_add_in[DW-1:0];
      enter_in    = (cmd_ff == fts_pkg::CMD_FRAME) && (frame_ff != '0)
                    && (warm_in >= warmup_ff);
      recomp_in   = !cready_ff || (rtot_in >= refresh_us_ff);
      wp_in       = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      fill_in     = (fill_ff == CW'(WINDOW_DEPTH)) ? fill_ff : fill_ff + 1'b1;
      few_in      = MW'(fill_in) < MW'(mins_ff);
   end

   assign mem_we  = (state_ff == STEP) && enter_in;
   assign rd_addr = issue_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= frame_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sorted insert into the descending top list
   always_comb begin
      for (int j = 0; j < TOPK; j++) begin
         if (rd_data_ff > top_ff[j]) begin
            if (j == 0) begin
               top_in[j] = rd_data_ff;
            end else begin
               top_in[j] = (rd_data_ff <= top_ff[(j == 0) ? 0 : j-1])
                           ? rd_data_ff : top_ff[(j == 0) ? 0 : j-1];
            end
         end else begin
            top_in[j] = top_ff[j];
         end
      end
   end

   // divider operand select and one restoring step
   always_comb begin
      unique case (sel_ff)
         2'd0:    begin k_sel = n_ff;  s_sel = total_ff; end
         2'd1:    begin k_sel = k1_ff; s_sel = tail1_ff; end
         default: begin k_sel = k2_ff; s_sel = tail2_ff; end
      endcase
      rem_sh = {rem_ff[SW-1:0], num_ff[NUM_W-1]};
      rem_ge = rem_sh >= {1'b0, div_ff};
      q_sat  = (num_ff > NUM_W'(fts_pkg::MAX24)) ? fts_pkg::MAX24 : num_ff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff     <= fts_pkg::WARMUP_RST;
         mins_ff       <= fts_pkg::MINS_RST;
         refresh_us_ff <= fts_pkg::REFRESH_RST;
         state_ff      <= IDLE;
         wp_ff         <= '0;
         fill_ff       <= '0;
         warm_ff       <= '0;
         rtot_ff       <= '0;
         cready_ff     <= 1'b0;
         mean_ff       <= '0;
         low1_ff       <= '0;
         low01_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               fts_pkg::CSR_WARMUP:  warmup_ff     <= csr_wdata;
               fts_pkg::CSR_MINS:    mins_ff       <= csr_wdata[fts_pkg::MINS_W-1:0];
               fts_pkg::CSR_REFRESH: refresh_us_ff <= csr_wdata;
               default: ;
            endcase
         end
         // PUB reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != PUB)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  frame_ff <= req_frame_us;
                  state_ff <= STEP;
               end
            end
            STEP: begin
               refr_ff  <= enter_in && recomp_in;
               state_ff <= (enter_in && recomp_in && !few_in) ? SCAN : PUB;
               if (cmd_ff == fts_pkg::CMD_CLEAR) begin
                  wp_ff     <= '0;
                  fill_ff   <= '0;
                  warm_ff   <= '0;
                  rtot_ff   <= '0;
                  cready_ff <= 1'b0;
                  mean_ff   <= '0;
                  low1_ff   <= '0;
                  low01_ff  <= '0;
               end else if (frame_ff != '0) begin
                  warm_ff <= warm_in;
                  if (enter_in) begin
                     wp_ff   <= wp_in;
                     fill_ff <= fill_in;
                     rtot_ff <= recomp_in ? '0 : rtot_in;
                     if (recomp_in) begin
                        if (few_in) begin
                           cready_ff <= 1'b0;
                           mean_ff   <= '0;
                           low1_ff   <= '0;
                           low01_ff  <= '0;
                        end else begin
                           n_ff     <= fill_in;
                           issue_ff <= '0;
                           total_ff <= '0;
                           c100_ff  <= '0;
                           c1000_ff <= '0;
                           k1_ff    <= '0;
                           k2_ff    <= '0;
                           for (int j = 0; j < TOPK; j++) begin
                              top_ff[j] <= '0;
                           end
                        end
                     end
                  end
               end
            end
            SCAN: begin
               // read issued this cycle lands in rd_data_ff next cycle
               rd_vld_ff <= (issue_ff != n_ff);
               if (issue_ff != n_ff) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (rd_vld_ff) begin
                  total_ff <= total_ff + SW'(rd_data_ff);
                  top_ff   <= top_in;
                  if (c100_ff == 7'd99) begin
                     c100_ff <= '0;
                     k1_ff   <= k1_ff + 1'b1;
                  end else begin
                     c100_ff <= c100_ff + 1'b1;
                  end
                  if (c1000_ff == 10'd999) begin
                     c1000_ff <= '0;
                     k2_ff    <= k2_ff + 1'b1;
                  end else begin
                     c1000_ff <= c1000_ff + 1'b1;
                  end
               end else if (issue_ff == n_ff) begin
                  if (k1_ff == '0) k1_ff <= CW'(1);
                  if (k2_ff == '0) k2_ff <= CW'(1);
                  tail1_ff <= '0;
                  tail2_ff <= '0;
                  tj_ff    <= '0;
                  state_ff <= TAIL;
               end
            end
            TAIL: begin
               // drain the top list head by head
               if (tj_ff < k1_ff) begin
                  tail1_ff <= tail1_ff + SW'(top_ff[0]);
                  if (tj_ff < k2_ff) begin
                     tail2_ff <= tail2_ff + SW'(top_ff[0]);
                  end
                  for (int j = 0; j < TOPK - 1; j++) begin
                     top_ff[j] <= top_ff[j+1];
                  end
                  top_ff[TOPK-1] <= '0;
                  tj_ff <= tj_ff + 1'b1;
               end else begin
                  sel_ff   <= 2'd0;
                  state_ff <= MUL;
               end
            end
            MUL: begin
               prod_ff  <= PW'(k_sel) * PW'(fts_pkg::RATE_SCALE);
               div_ff   <= s_sel;
               state_ff <= DLOAD;
            end
            DLOAD: begin
               num_ff   <= NUM_W'(prod_ff) + NUM_W'(div_ff >> 1);
               rem_ff   <= '0;
               bit_ff   <= BW'(NUM_W);
               state_ff <= DRUN;
            end
            DRUN: begin
               if (bit_ff != '0) begin
                  rem_ff <= rem_ge ? rem_sh - {1'b0, div_ff} : rem_sh;
                  num_ff <= {num_ff[NUM_W-2:0], rem_ge};
                  bit_ff <= bit_ff - 1'b1;
               end else begin
                  unique case (sel_ff)
                     2'd0:    mean_ff  <= q_sat;
                     2'd1:    low1_ff  <= q_sat;
                     default: low01_ff <= q_sat;
                  endcase
                  if (sel_ff == 2'd2) begin
                     cready_ff <= 1'b1;
                     state_ff  <= PUB;
                  end else begin
                     sel_ff   <= sel_ff + 1'b1;
                     state_ff <= MUL;
                  end
               end
            end
            PUB: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ready_flag_ff <= cready_ff;
                  rsp_mean_ff       <= mean_ff;
                  rsp_low1_ff       <= low1_ff;
                  rsp_low01_ff      <= low01_ff;
                  rsp_refr_ff       <= refr_ff;
                  state_ff          <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready              = (state_ff == IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_stats_ready        = rsp_ready_flag_ff;
   assign rsp_mean_rate          = rsp_mean_ff;
   assign rsp_low_one_pct_rate   = rsp_low1_ff;
   assign rsp_low_tenth_pct_rate = rsp_low01_ff;
   assign rsp_refreshed          = rsp_refr_ff;

   `FTS_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CW'(WINDOW_DEPTH))
   `FTS_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
   `FTS_ASSERT_NOW(a_mean_live, cready_ff, mean_ff != '0)
   `FTS_ASSERT_NOW(a_tail_bound, state_ff == TAIL, k2_ff <= k1_ff)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame time window stats testbench
// Sends frame and clear beats and runs a window-statistics predictor next to
// the block. Each result beat is compared field by field with the oldest
// predicted stats. Runs through several warm-up, min-samples and refresh
// settings, with random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned DW = fts_pkg::DATA_W;
   localparam int unsigned DEPTH = 1000;
   localparam int unsigned TAIL_CAP = DEPTH / 100 + 1;
   localparam longint unsigned CYCLE_LIMIT = 2_500_000;

   typedef struct packed {
      logic              ready;
      logic [DW-1:0]     mean;
      logic [DW-1:0]     low1;
      logic [DW-1:0]     low01;
      logic              refreshed;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = fts_pkg::CMD_FRAME;
   logic [DW-1:0] req_frame_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_stats_ready;
   logic [DW-1:0] rsp_mean_rate, rsp_low_one_pct_rate, rsp_low_tenth_pct_rate;
   logic rsp_refreshed;
   logic csr_wr_en = 1'b0;
   logic [fts_pkg::CSR_W-1:0] csr_index = fts_pkg::CSR_WARMUP;
   logic [DW-1:0] csr_wdata = '0;

   frame_time_window_stats #(.WINDOW_DEPTH(DEPTH)) DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of config and statistics state
   logic [DW-1:0] cfg_warmup, cfg_refresh;
   logic [fts_pkg::MINS_W-1:0] cfg_mins;
   logic [DW-1:0] win [DEPTH];
   int unsigned wr_ptr, fill;
   logic [DW-1:0] warm_tot, refr_tot;
   logic cache_ok;
   logic [DW-1:0] cache_rate [3];

   stats_type expected_stats [$];
   int unsigned mismatches = 0;
   int unsigned beats_sent = 0, results_seen = 0, refresh_count = 0, ready_seen = 0;
   int unsigned send_idle_pct = 0, recv_idle_pct = 0;
   bit hold_rsp = 0;
   longint unsigned cycles = 0;

   function automatic logic [DW-1:0] sat_sum(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW:0] s;
      s = a + b;
      return s > fts_pkg::MAX24 ? fts_pkg::MAX24 : s[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] fps_q8(longint unsigned k, longint unsigned s);
      longint unsigned q;
      if (s == 0) return fts_pkg::MAX24;
      q = (k * 256000000 + s / 2) / s;
      return q > fts_pkg::MAX24 ? fts_pkg::MAX24 : q[DW-1:0];
   endfunction

   task automatic clear_window_state();
      wr_ptr = 0; fill = 0; warm_tot = '0; refr_tot = '0; cache_ok = 0;
      for (int i = 0; i < 3; i++) cache_rate[i] = '0;
   endtask

   task automatic recompute_rates();
      logic [DW-1:0] w [DEPTH];
      int unsigned n, k1, k2, best;
      longint unsigned tot, t1, t2;
      logic [DW-1:0] t;
      n = fill; tot = 0; t1 = 0; t2 = 0;
      if (n < cfg_mins || n == 0) begin
         cache_ok = 0;
         for (int i = 0; i < 3; i++) cache_rate[i] = '0;
         return;
      end
      for (int i = 0; i < n; i++) begin
         w[i] = win[i];
         tot += w[i];
      end
      k1 = (n / 100 < 1) ? 1 : n / 100;
      k2 = (n / 1000 < 1) ? 1 : n / 1000;
      for (int i = 0; i < k1 && i < TAIL_CAP && i < n; i++) begin
         best = i;
         for (int j = i + 1; j < n; j++) if (w[j] > w[best]) best = j;
         t = w[i]; w[i] = w[best]; w[best] = t;
         t1 += w[i];
         if (i < k2) t2 += w[i];
      end
      cache_rate[0] = fps_q8(n, tot);
      cache_rate[1] = fps_q8(k1, t1);
      cache_rate[2] = fps_q8(k2, t2);
      cache_ok = 1;
   endtask

   task automatic predict_stats(logic cmd, logic [DW-1:0] us);
      stats_type r;
      r.refreshed = 0;
      if (cmd == fts_pkg::CMD_CLEAR) clear_window_state();
      else if (us != 0) begin
         warm_tot = sat_sum(warm_tot, us);
         if (warm_tot >= cfg_warmup) begin
            win[wr_ptr] = us;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (fill < DEPTH) fill++;
            refr_tot = sat_sum(refr_tot, us);
            if (!cache_ok || refr_tot >= cfg_refresh) begin
               recompute_rates();
               refr_tot = '0;
               r.refreshed = 1;
            end
         end
      end
      r.ready = cache_ok; r.mean = cache_rate[0];
      r.low1 = cache_rate[1]; r.low01 = cache_rate[2];
      expected_stats.push_back(r);
   endtask

   // one beat on req, with a random idle gap in front; valid drops after the
   // accept, while the block is busy anyway
   task automatic send_frame(logic cmd, logic [DW-1:0] us);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1; req_command <= cmd; req_frame_us <= us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_stats(cmd, us);
      beats_sent++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (1300) @(posedge clock);   // block may still be busy
   endtask

   task automatic write_csr(logic [fts_pkg::CSR_W-1:0] idx, logic [DW-1:0] val);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      case (idx)
         fts_pkg::CSR_WARMUP:  cfg_warmup = val;
         fts_pkg::CSR_MINS:    cfg_mins = val[fts_pkg::MINS_W-1:0];
         fts_pkg::CSR_REFRESH: cfg_refresh = val;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [DW-1:0] wu, logic [DW-1:0] ms,
                             logic [DW-1:0] rf);
      wait_drained();
      write_csr(fts_pkg::CSR_WARMUP, wu);
      write_csr(fts_pkg::CSR_MINS, ms);
      write_csr(fts_pkg::CSR_REFRESH, rf);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [DW-1:0] rand_frame();
      case ($urandom_range(9))
         0:       return DW'($urandom);                       // full 24-bit range
         1:       return fts_pkg::MAX24 - DW'($urandom_range(3));
         2:       return DW'($urandom_range(1, 4));
         default: return DW'($urandom_range(5000, 60000));    // typical frame times
      endcase
   endfunction

   // reset values: long warm-up with short frames; also saturating frames
   task automatic test_reset_defaults();
      send_frame(fts_pkg::CMD_FRAME, 24'd0);
      send_frame(fts_pkg::CMD_FRAME, 24'd1);
      send_frame(fts_pkg::CMD_FRAME, 24'd2999998);
      send_frame(fts_pkg::CMD_FRAME, 24'd16667);  // crosses warm-up, min_samples 100 not met
      send_frame(fts_pkg::CMD_FRAME, fts_pkg::MAX24);
      send_frame(fts_pkg::CMD_CLEAR, fts_pkg::MAX24);  // clear ignores frame_us
      send_frame(fts_pkg::CMD_FRAME, fts_pkg::MAX24);  // takes warm-up total to its maximum
      send_frame(fts_pkg::CMD_FRAME, 24'd0);
   endtask

   // warm-up off; min_samples 1, refresh 0: every sample recomputes, extreme rates; then min_samples 0 and 1023
   task automatic test_extremes();
      set_config(24'd0, 24'd1, 24'd0);
      send_frame(fts_pkg::CMD_FRAME, 24'd1);          // rate saturates
      send_frame(fts_pkg::CMD_FRAME, fts_pkg::MAX24);
      send_frame(fts_pkg::CMD_FRAME, 24'hAAAAAA);
      send_frame(fts_pkg::CMD_FRAME, 24'h555555);
      send_frame(fts_pkg::CMD_FRAME, 24'd0);
      send_frame(fts_pkg::CMD_CLEAR, 24'd0);
      send_frame(fts_pkg::CMD_FRAME, 24'd7);
      set_config(24'd0, 24'd0, fts_pkg::MAX24);       // min_samples zero acts as one
      send_frame(fts_pkg::CMD_FRAME, 24'd3);
      send_frame(fts_pkg::CMD_FRAME, 24'd5);
      set_config(24'd0, 24'd1023, 24'd1);             // above depth: never ready
      send_frame(fts_pkg::CMD_FRAME, 24'd16000);
      send_frame(fts_pkg::CMD_FRAME, 24'd17000);
      send_frame(fts_pkg::CMD_CLEAR, 24'd0);
   endtask

   task automatic random_run(int unsigned count, int unsigned clear_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < clear_pct)
            send_frame(fts_pkg::CMD_CLEAR, DW'($urandom));
         else if ($urandom_range(19) == 0) send_frame(fts_pkg::CMD_FRAME, 24'd0);
         else send_frame(fts_pkg::CMD_FRAME, rand_frame());
      end
   endtask

   // sender keeps offering while rsp is held off, so the block backs up
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         random_run(12, 0);
      join
      wait_drained();
      random_run(8, 0);
   endtask

   task automatic test_random();
      set_config(24'd50000, 24'd20, 24'd100000);
      send_idle_pct = 12; recv_idle_pct = 86;
      random_run(150, 2);
      set_config(24'd0, 24'd5, 24'd0);
      send_idle_pct = 86; recv_idle_pct = 12;
      random_run(150, 3);
      set_config(24'd200000, 24'd100, 24'd300000);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_run(150, 1);
   endtask

   // receiver idling and the long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      stats_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_stats_ready, rsp_mean_rate, rsp_low_one_pct_rate,
                 rsp_low_tenth_pct_rate, rsp_refreshed};
         results_seen++;
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
         end else begin
            want = expected_stats.pop_front();
            if (want.refreshed) refresh_count++;
            if (want.ready) ready_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d mismatch: expected %p got %p",
                           results_seen, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      cfg_warmup = fts_pkg::WARMUP_RST;
      cfg_mins = fts_pkg::MINS_RST;
      cfg_refresh = fts_pkg::REFRESH_RST;
      clear_window_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      set_config(24'd0, 24'd1, 24'd50000);
      test_backpressure();
      test_random();
      wait_drained();
      $display("covered %0d beats, %0d results, %0d recomputes, %0d ready results",
               beats_sent, results_seen, refresh_count, ready_seen);
      if (mismatches == 0 && expected_stats.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  expected_stats.size());
         $display("tb failed");
      end
      $finish;
   end
endmodule
